/* rtl/hge_pkg.sv */
package hge_pkg;

   localparam int MAX_DIM     = 1024;
   localparam int DIM_W       = 11;
   localparam int COORD_W     = 10;
   localparam int NODE_W      = 20;
   localparam int CFG_W       = 64;
   localparam int CSR_IDX_W   = 3;
   localparam int NUM_NBR     = 4;
   localparam int NUM_LANE    = NUM_NBR + 1;
   localparam int QUEUE_DEPTH = 16;

   localparam logic [63:0] MIX_ADD  = 64'h9e3779b97f4a7c15;
   localparam logic [63:0] MIX_MUL1 = 64'hbf58476d1ce4e5b9;
   localparam logic [63:0] MIX_MUL2 = 64'h94d049bb133111eb;

   localparam logic [CSR_IDX_W-1:0] CSR_GRID_WIDTH      = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_GRID_HEIGHT     = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_HASH_SEED       = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_BLOCK_THRESHOLD = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_BLOCK_ALL       = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_DIAGONAL_MODE   = 3'd5;

   typedef logic [NODE_W-1:0] node_type;

   typedef struct packed {
      node_type                  from_node;
      node_type [NUM_NBR-1:0]    to_node;
      logic     [NUM_NBR-1:0]    nbr_mask;
   } edge_set_type;

   typedef struct packed {
      logic         valid;
      edge_set_type edges;
   } cand_type;

endpackage

/* rtl/hge_index.sv */
module hge_index (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        accept,
   input  logic [hge_pkg::COORD_W-1:0] col,
   input  logic [hge_pkg::COORD_W-1:0] row,
   input  logic [hge_pkg::DIM_W-1:0]   grid_width,
   input  logic [hge_pkg::DIM_W-1:0]   grid_height,
   input  logic                        diagonal_mode,
   output hge_pkg::cand_type           cand
);
   import hge_pkg::*;

   logic [DIM_W-1:0]         w;
   logic [DIM_W-1:0]         h;
   logic [COORD_W+DIM_W-1:0] prod;
   logic [COORD_W+DIM_W-1:0] lin;

   logic         a_valid_ff;
   node_type     a_node_ff;
   node_type     a_node_in;
   logic         a_in_range_ff, a_in_range_in;
   logic         a_right_ff, a_right_in;
   logic         a_down_ff, a_down_in;
   logic         a_left_ff, a_left_in;

   logic         b_valid_ff;
   edge_set_type b_edges_ff;
   edge_set_type b_edges_in;
   node_type     below;

   always_comb begin
      w = (grid_width > DIM_W'(MAX_DIM)) ? DIM_W'(MAX_DIM) : grid_width;
      h = (grid_height > DIM_W'(MAX_DIM)) ? DIM_W'(MAX_DIM) : grid_height;
      prod = row * w;
      lin = prod + (COORD_W+DIM_W)'(col);
      a_node_in = lin[NODE_W-1:0];
      a_in_range_in = (DIM_W'(col) < w) && (DIM_W'(row) < h);
      a_right_in = (DIM_W'(col) + DIM_W'(1)) < w;
      a_down_in = (DIM_W'(row) + DIM_W'(1)) < h;
      a_left_in = (col != '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
      end else begin
         a_valid_ff <= accept;
         b_valid_ff <= a_valid_ff;
      end
   end

   always_comb begin
      below = a_node_ff + NODE_W'(w);
      b_edges_in.from_node  = a_node_ff;
      b_edges_in.to_node[0] = a_node_ff + NODE_W'(1);
      b_edges_in.to_node[1] = below;
      b_edges_in.to_node[2] = below + NODE_W'(1);
      b_edges_in.to_node[3] = below - NODE_W'(1);
      b_edges_in.nbr_mask[0] = a_in_range_ff & a_right_ff;
      b_edges_in.nbr_mask[1] = a_in_range_ff & a_down_ff;
      b_edges_in.nbr_mask[2] = a_in_range_ff & a_down_ff & a_right_ff & diagonal_mode;
      b_edges_in.nbr_mask[3] = a_in_range_ff & a_down_ff & a_left_ff & diagonal_mode;
   end

   always_ff @(posedge clock) begin
      a_node_ff     <= a_node_in;
      a_in_range_ff <= a_in_range_in;
      a_right_ff    <= a_right_in;
      a_down_ff     <= a_down_in;
      a_left_ff     <= a_left_in;
      b_edges_ff    <= b_edges_in;
   end

   assign cand.valid = b_valid_ff;
   assign cand.edges = b_edges_ff;

endmodule

/* rtl/hge_mix.sv */
module hge_mix (
   input  logic                      clock,
   input  hge_pkg::node_type         node,
   input  logic [hge_pkg::CFG_W-1:0] hash_seed,
   input  logic [hge_pkg::CFG_W-1:0] block_threshold,
   input  logic                      block_all,
   output logic                      blocked
);
   import hge_pkg::*;

   logic [63:0] v;
   logic [63:0] z1_ff, z1_in;
   logic [63:0] p1_ll_ff, p1_ll_in;
   logic [31:0] p1_lh_ff, p1_lh_in;
   logic [31:0] p1_hl_ff, p1_hl_in;
   logic [31:0] p1_cross;
   logic [63:0] m1;
   logic [63:0] z2_ff, z2_in;
   logic [63:0] p2_ll_ff, p2_ll_in;
   logic [31:0] p2_lh_ff, p2_lh_in;
   logic [31:0] p2_hl_ff, p2_hl_in;
   logic [31:0] p2_cross;
   logic [63:0] m2;
   logic [63:0] hash;
   logic        blocked_ff, blocked_in;

   always_comb begin
      v = (hash_seed ^ CFG_W'(node)) + MIX_ADD;
      z1_in = v ^ (v >> 30);

      p1_ll_in = z1_ff[31:0] * MIX_MUL1[31:0];
      p1_lh_in = z1_ff[31:0] * MIX_MUL1[63:32];
      p1_hl_in = z1_ff[63:32] * MIX_MUL1[31:0];

      p1_cross = p1_lh_ff + p1_hl_ff;
      m1 = p1_ll_ff + {p1_cross, 32'd0};
      z2_in = m1 ^ (m1 >> 27);

      p2_ll_in = z2_ff[31:0] * MIX_MUL2[31:0];
      p2_lh_in = z2_ff[31:0] * MIX_MUL2[63:32];
      p2_hl_in = z2_ff[63:32] * MIX_MUL2[31:0];

      p2_cross = p2_lh_ff + p2_hl_ff;
      m2 = p2_ll_ff + {p2_cross, 32'd0};
      hash = m2 ^ (m2 >> 31);
      blocked_in = block_all | (hash < block_threshold);
   end

   always_ff @(posedge clock) begin
      z1_ff      <= z1_in;
      p1_ll_ff   <= p1_ll_in;
      p1_lh_ff   <= p1_lh_in;
      p1_hl_ff   <= p1_hl_in;
      z2_ff      <= z2_in;
      p2_ll_ff   <= p2_ll_in;
      p2_lh_ff   <= p2_lh_in;
      p2_hl_ff   <= p2_hl_in;
      blocked_ff <= blocked_in;
   end

   assign blocked = blocked_ff;

endmodule

/* rtl/hge_queue.sv */
module hge_queue #(
   parameter int DEPTH = hge_pkg::QUEUE_DEPTH
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  accept,
   input  logic                  push,
   input  hge_pkg::edge_set_type push_set,
   input  logic                  drop,
   output logic                  busy,
   output logic                  rsp_valid,
   output hge_pkg::node_type     rsp_from_node,
   output hge_pkg::node_type     rsp_to_node,
   output logic                  rsp_last_edge
);
   import hge_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int SEL_W = $clog2(NUM_NBR);

   edge_set_type fifo_mem [DEPTH];
   edge_set_type head;

   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] fill_ff, fill_in;
   logic [CNT_W-1:0] credit_ff, credit_in;

   logic                      cur_valid_ff, cur_valid_in;
   node_type                  cur_from_ff;
   node_type [NUM_NBR-1:0]    cur_to_ff;
   logic     [NUM_NBR-1:0]    cur_mask_ff, cur_mask_in;

   logic [SEL_W-1:0]   sel;
   logic [NUM_NBR-1:0] rest;
   logic               emit;
   logic               cur_last;
   logic               pop;

   logic     rsp_valid_ff;
   node_type rsp_from_ff, rsp_to_ff;
   logic     rsp_last_ff;

   assign head = fifo_mem[rd_ptr_ff];

   always_comb begin
      sel = '0;
      for (int i = NUM_NBR - 1; i >= 0; i--) begin
         if (cur_mask_ff[i]) begin
            sel = SEL_W'(i);
         end
      end
      rest = cur_mask_ff & ~(NUM_NBR'(1) << sel);
      emit = cur_valid_ff;
      cur_last = emit && (rest == '0);
      pop = (!cur_valid_ff || cur_last) && (fill_ff != '0);

      wr_ptr_in = wr_ptr_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      rd_ptr_in = rd_ptr_ff;
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      fill_in = fill_ff + CNT_W'(push) - CNT_W'(pop);
      credit_in = credit_ff + CNT_W'(accept) - CNT_W'(pop) - CNT_W'(drop);

      priority if (pop) begin
         cur_valid_in = 1'b1;
         cur_mask_in = head.nbr_mask;
      end else if (emit) begin
         cur_valid_in = (rest != '0);
         cur_mask_in = rest;
      end else begin
         cur_valid_in = cur_valid_ff;
         cur_mask_in = cur_mask_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff    <= '0;
         rd_ptr_ff    <= '0;
         fill_ff      <= '0;
         credit_ff    <= '0;
         cur_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         wr_ptr_ff    <= wr_ptr_in;
         rd_ptr_ff    <= rd_ptr_in;
         fill_ff      <= fill_in;
         credit_ff    <= credit_in;
         cur_valid_ff <= cur_valid_in;
         rsp_valid_ff <= emit;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         fifo_mem[wr_ptr_ff] <= push_set;
      end
      if (pop) begin
         cur_from_ff <= head.from_node;
         cur_to_ff   <= head.to_node;
      end
      cur_mask_ff <= cur_mask_in;
      rsp_from_ff <= cur_from_ff;
      rsp_to_ff   <= cur_to_ff[sel];
      rsp_last_ff <= cur_last;
   end

   assign busy          = (credit_ff == CNT_W'(DEPTH));
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_from_node = rsp_from_ff;
   assign rsp_to_node   = rsp_to_ff;
   assign rsp_last_edge = rsp_last_ff;

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      (push && (fill_ff == CNT_W'(DEPTH))) |-> pop)
      else $error("edge queue written while full");

   a_credit_covers_fill: assert property (@(posedge clock) disable iff (reset)
      credit_ff >= fill_ff)
      else $error("queue holds more words than were admitted");

   a_cur_not_empty: assert property (@(posedge clock) disable iff (reset)
      cur_valid_ff |-> (cur_mask_ff != '0))
      else $error("active cell has no edge left");

   a_one_source: assert property (@(posedge clock) disable iff (reset)
      !(push && drop))
      else $error("cell both queued and dropped");

   a_last_closes: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_last_ff) |-> cur_valid_ff)
      else $error("cell closed without a last word");

endmodule

/* rtl/hashed_grid_edge_emitter_core.sv */
// Hashed blocked-grid edge emitter.
//
// Request side: drive req_col/req_row with start; the cell is taken at a rising
// edge where start is high and busy is low. Cells may be issued every cycle.
// Response side: each edge appears for one cycle with rsp_valid high; the last
// edge of a cell carries rsp_last_edge. A blocked, out-of-range or isolated
// cell yields no word. The receiver has no way to stall the block.
// Configuration: csr_write_en with csr_index/csr_data writes one register
// immediately; write only while no cell is in flight.
//
// Order: index stages, hash lanes and delay line, edge queue, response registers.
// Throughput: one word per cycle on the response side, so a cell with edges
// occupies one cycle per edge there (up to 4) and a cell with none takes no
// slot. The hash pipeline takes a cell every cycle; busy rises when QUEUE_DEPTH
// cells are admitted but neither dropped nor yet started on the response side.
// Reset: registers return to width 1, height 1, seed 1, threshold 0, block-all
// off, four-connected; all pipeline stages and the edge queue are emptied.
module hashed_grid_edge_emitter_core #(
   parameter int QUEUE_DEPTH = hge_pkg::QUEUE_DEPTH
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic [hge_pkg::COORD_W-1:0]   req_col,
   input  logic [hge_pkg::COORD_W-1:0]   req_row,
   output logic                          rsp_valid,
   output logic [hge_pkg::NODE_W-1:0]    rsp_from_node,
   output logic [hge_pkg::NODE_W-1:0]    rsp_to_node,
   output logic                          rsp_last_edge,
   input  logic                          csr_write_en,
   input  logic [hge_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [hge_pkg::CFG_W-1:0]     csr_data
);
   import hge_pkg::*;

   localparam int SIDE_DEPTH = 5;

   logic [DIM_W-1:0] grid_width_ff;
   logic [DIM_W-1:0] grid_height_ff;
   logic [CFG_W-1:0] hash_seed_ff;
   logic [CFG_W-1:0] block_threshold_ff;
   logic             block_all_ff;
   logic             diagonal_mode_ff;

   logic         accept;
   cand_type     cand;
   node_type     lane_node [NUM_LANE];
   logic [NUM_LANE-1:0] lane_blocked;

   logic [SIDE_DEPTH-1:0] side_valid_ff;
   edge_set_type          side_edges_ff [SIDE_DEPTH];

   logic [NUM_NBR-1:0] nbr_ok;
   logic               push;
   logic               drop;
   edge_set_type       push_set;
   node_type           rsp_from_w, rsp_to_w;

   assign accept = start && !busy;

   always_ff @(posedge clock) begin
      if (reset) begin
         grid_width_ff      <= DIM_W'(1);
         grid_height_ff     <= DIM_W'(1);
         hash_seed_ff       <= CFG_W'(1);
         block_threshold_ff <= '0;
         block_all_ff       <= 1'b0;
         diagonal_mode_ff   <= 1'b0;
      end else if (csr_write_en) begin
         unique case (csr_index)
            CSR_GRID_WIDTH: begin
               grid_width_ff <= csr_data[DIM_W-1:0];
            end
            CSR_GRID_HEIGHT: begin
               grid_height_ff <= csr_data[DIM_W-1:0];
            end
            CSR_HASH_SEED: begin
               hash_seed_ff <= csr_data;
            end
            CSR_BLOCK_THRESHOLD: begin
               block_threshold_ff <= csr_data;
            end
            CSR_BLOCK_ALL: begin
               block_all_ff <= csr_data[0];
            end
            CSR_DIAGONAL_MODE: begin
               diagonal_mode_ff <= csr_data[0];
            end
            default: begin
            end
         endcase
      end
   end

   hge_index u_index (
      .clock         (clock),
      .reset         (reset),
      .accept        (accept),
      .col           (req_col),
      .row           (req_row),
      .grid_width    (grid_width_ff),
      .grid_height   (grid_height_ff),
      .diagonal_mode (diagonal_mode_ff),
      .cand          (cand)
   );

   assign lane_node[0] = cand.edges.from_node;

   for (genvar g = 1; g < NUM_LANE; g++) begin : g_lane_node
      assign lane_node[g] = cand.edges.to_node[g-1];
   end

   for (genvar g = 0; g < NUM_LANE; g++) begin : g_lane
      hge_mix u_mix (
         .clock           (clock),
         .node            (lane_node[g]),
         .hash_seed       (hash_seed_ff),
         .block_threshold (block_threshold_ff),
         .block_all       (block_all_ff),
         .blocked         (lane_blocked[g])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         side_valid_ff <= '0;
      end else begin
         side_valid_ff <= {side_valid_ff[SIDE_DEPTH-2:0], cand.valid};
      end
   end

   always_ff @(posedge clock) begin
      side_edges_ff[0] <= cand.edges;
      for (int i = 1; i < SIDE_DEPTH; i++) begin
         side_edges_ff[i] <= side_edges_ff[i-1];
      end
   end

   always_comb begin
      nbr_ok = side_edges_ff[SIDE_DEPTH-1].nbr_mask & ~lane_blocked[NUM_LANE-1:1];
      push = side_valid_ff[SIDE_DEPTH-1] && !lane_blocked[0] && (nbr_ok != '0);
      drop = side_valid_ff[SIDE_DEPTH-1] && !push;
      push_set.from_node = side_edges_ff[SIDE_DEPTH-1].from_node;
      push_set.to_node   = side_edges_ff[SIDE_DEPTH-1].to_node;
      push_set.nbr_mask  = nbr_ok;
   end

   hge_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock         (clock),
      .reset         (reset),
      .accept        (accept),
      .push          (push),
      .push_set      (push_set),
      .drop          (drop),
      .busy          (busy),
      .rsp_valid     (rsp_valid),
      .rsp_from_node (rsp_from_w),
      .rsp_to_node   (rsp_to_w),
      .rsp_last_edge (rsp_last_edge)
   );

   assign rsp_from_node = rsp_from_w;
   assign rsp_to_node   = rsp_to_w;

endmodule

/* tb/tb.sv */
`timescale 1ns / 1ps
module tb;
   import hge_pkg::*;

   localparam logic [CSR_IDX_W-1:0] CSR_RSVD_A = 3'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_RSVD_B = 3'd7;
   localparam int DRAIN_CYCLES    = 40;
   localparam int PREDICTED       = -1;
   localparam int NUM_PHASES      = 8;
   localparam int ITEMS_PER_PHASE = 32;
   localparam int MAX_REPORTS     = 10;

   typedef struct packed {
      node_type from_node;
      node_type to_node;
      logic     last_edge;
   } edge_word_type;

   typedef struct {
      logic                   is_csr;
      logic [CSR_IDX_W-1:0]   idx;
      logic [CFG_W-1:0]       data;
      logic [COORD_W-1:0]     col;
      logic [COORD_W-1:0]     row;
      int                     n_fixed;
      node_type               from_fixed;
      node_type [NUM_NBR-1:0] to_fixed;
   } stim_row_type;

   logic                 clock;
   logic                 reset;
   logic                 start;
   logic                 busy;
   logic [COORD_W-1:0]   req_col;
   logic [COORD_W-1:0]   req_row;
   logic                 rsp_valid;
   logic [NODE_W-1:0]    rsp_from_node;
   logic [NODE_W-1:0]    rsp_to_node;
   logic                 rsp_last_edge;
   logic                 csr_write_en;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [CFG_W-1:0]     csr_data;

   logic [DIM_W-1:0] grid_w_cfg;
   logic [DIM_W-1:0] grid_h_cfg;
   logic [63:0]      seed_cfg;
   logic [63:0]      thresh_cfg;
   logic             block_all_cfg;
   logic             diag_cfg;

   edge_word_type pending_edges[$];
   int            mismatch_count = 0;
   int            idle_pct = 0;
   bit            start_held = 1'b0;

   hashed_grid_edge_emitter_core u_top (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_col       (req_col),
      .req_row       (req_row),
      .rsp_valid     (rsp_valid),
      .rsp_from_node (rsp_from_node),
      .rsp_to_node   (rsp_to_node),
      .rsp_last_edge (rsp_last_edge),
      .csr_write_en  (csr_write_en),
      .csr_index     (csr_index),
      .csr_data      (csr_data)
   );

   initial clock = 1'b0;
   always #10 clock = ~clock;

   function automatic logic [63:0] splitmix(input logic [63:0] v);
      logic [63:0] z;
      z = v + MIX_ADD;
      z = (z ^ (z >> 30)) * MIX_MUL1;
      z = (z ^ (z >> 27)) * MIX_MUL2;
      return z ^ (z >> 31);
   endfunction

   function automatic logic cell_is_blocked(input logic [63:0] node);
      return block_all_cfg || (splitmix(seed_cfg ^ node) < thresh_cfg);
   endfunction

   task automatic predict_cell_edges(input logic [COORD_W-1:0] col,
                                     input logic [COORD_W-1:0] row);
      logic [63:0]   w, h, x, y, u;
      logic [63:0]   nbr[$];
      edge_word_type hits[$];
      edge_word_type e;
      w = (grid_w_cfg > MAX_DIM) ? 64'(MAX_DIM) : 64'(grid_w_cfg);
      h = (grid_h_cfg > MAX_DIM) ? 64'(MAX_DIM) : 64'(grid_h_cfg);
      x = 64'(col);
      y = 64'(row);
      if (x >= w || y >= h) return;
      u = y * w + x;
      if (cell_is_blocked(u)) return;
      if (x + 1 < w) nbr = {nbr, u + 64'd1};
      if (y + 1 < h) nbr = {nbr, u + w};
      if (diag_cfg && y + 1 < h) begin
         if (x + 1 < w) nbr = {nbr, u + w + 64'd1};
         if (x >= 1) nbr = {nbr, u + w - 64'd1};
      end
      foreach (nbr[k]) begin
         if (!cell_is_blocked(nbr[k])) begin
            e.from_node = u[NODE_W-1:0];
            e.to_node   = nbr[k][NODE_W-1:0];
            e.last_edge = 1'b0;
            hits = {hits, e};
         end
      end
      if (hits.size() > 0) hits[hits.size()-1].last_edge = 1'b1;
      foreach (hits[k]) pending_edges = {pending_edges, hits[k]};
   endtask

   function automatic stim_row_type cell_row(input int col, input int row, input int n,
                                             input int from = 0, input int t0 = 0,
                                             input int t1 = 0, input int t2 = 0,
                                             input int t3 = 0);
      stim_row_type r;
      r.is_csr     = 1'b0;
      r.idx        = '0;
      r.data       = '0;
      r.col        = col[COORD_W-1:0];
      r.row        = row[COORD_W-1:0];
      r.n_fixed    = n;
      r.from_fixed = from[NODE_W-1:0];
      r.to_fixed   = {node_type'(t3), node_type'(t2), node_type'(t1), node_type'(t0)};
      return r;
   endfunction

   function automatic stim_row_type csr_row(input logic [CSR_IDX_W-1:0] idx,
                                            input logic [CFG_W-1:0] data);
      stim_row_type r;
      r = cell_row(0, 0, 0);
      r.is_csr = 1'b1;
      r.idx    = idx;
      r.data   = data;
      return r;
   endfunction

   function automatic logic [63:0] pick_dim();
      logic [63:0] v;
      v = {$urandom, $urandom};
      case ($urandom_range(9))
         0: v[DIM_W-1:0] = DIM_W'(MAX_DIM);
         1: v[DIM_W-1:0] = DIM_W'($urandom_range(2047, MAX_DIM + 1));
         2: v[DIM_W-1:0] = DIM_W'(1);
         default: v[DIM_W-1:0] = DIM_W'($urandom_range(12, 2));
      endcase
      return v;
   endfunction

   task automatic lower_start();
      if (start_held) begin
         start <= 1'b0;
         start_held = 1'b0;
      end
   endtask

   task automatic drain();
      lower_start();
      while (pending_edges.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
      drain();
      csr_index    <= idx;
      csr_data     <= data;
      csr_write_en <= 1'b1;
      @(posedge clock);
      csr_write_en <= 1'b0;
      case (idx)
         CSR_GRID_WIDTH:      grid_w_cfg = data[DIM_W-1:0];
         CSR_GRID_HEIGHT:     grid_h_cfg = data[DIM_W-1:0];
         CSR_HASH_SEED:       seed_cfg = data;
         CSR_BLOCK_THRESHOLD: thresh_cfg = data;
         CSR_BLOCK_ALL:       block_all_cfg = data[0];
         CSR_DIAGONAL_MODE:   diag_cfg = data[0];
         default: ;
      endcase
   endtask

   task automatic send_cell(input stim_row_type r);
      int            gap;
      edge_word_type e;
      gap = 0;
      while ($urandom_range(99) < idle_pct) gap++;
      if (gap > 0) begin
         lower_start();
         repeat (gap) @(posedge clock);
      end
      req_col <= r.col;
      req_row <= r.row;
      start   <= 1'b1;
      start_held = 1'b1;
      do @(posedge clock); while (busy);
      if (r.n_fixed == PREDICTED) begin
         predict_cell_edges(r.col, r.row);
      end else begin
         for (int k = 0; k < r.n_fixed; k++) begin
            e.from_node = r.from_fixed;
            e.to_node   = r.to_fixed[k];
            e.last_edge = (k == r.n_fixed - 1);
            pending_edges = {pending_edges, e};
         end
      end
   endtask

   always @(posedge clock) begin
      edge_word_type want;
      if (!reset && rsp_valid) begin
         if (pending_edges.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS)
               $display("unexpected word: %0d -> %0d last %0b",
                        rsp_from_node, rsp_to_node, rsp_last_edge);
         end else begin
            want = pending_edges.pop_front();
            if (rsp_from_node !== want.from_node || rsp_to_node !== want.to_node ||
                rsp_last_edge !== want.last_edge) begin
               mismatch_count++;
               if (mismatch_count <= MAX_REPORTS)
                  $display("word mismatch: expected %0d -> %0d last %0b, got %0d -> %0d last %0b",
                           want.from_node, want.to_node, want.last_edge,
                           rsp_from_node, rsp_to_node, rsp_last_edge);
            end
         end
      end
   end

   initial begin
      #5_000_000;
      $display("Regression FAIL");
      $finish;
   end

   initial begin
      stim_row_type rows[$];
      logic [63:0]  v;
      int           w_eff, h_eff, col, row;

      reset        <= 1'b1;
      start        <= 1'b0;
      req_col      <= '0;
      req_row      <= '0;
      csr_write_en <= 1'b0;
      csr_index    <= '0;
      csr_data     <= '0;
      grid_w_cfg    = DIM_W'(1);
      grid_h_cfg    = DIM_W'(1);
      seed_cfg      = 64'd1;
      thresh_cfg    = '0;
      block_all_cfg = 1'b0;
      diag_cfg      = 1'b0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      rows = {rows, cell_row(0, 0, 0)};
      rows = {rows, cell_row(1023, 1023, 0)};
      rows = {rows, csr_row(CSR_GRID_WIDTH, 64'd4)};
      rows = {rows, csr_row(CSR_GRID_HEIGHT, 64'd3)};
      rows = {rows, cell_row(0, 0, 2, 0, 1, 4)};
      rows = {rows, cell_row(3, 2, 0)};
      rows = {rows, cell_row(3, 0, 1, 3, 7)};
      rows = {rows, cell_row(0, 2, 1, 8, 9)};
      rows = {rows, cell_row(4, 0, 0)};
      rows = {rows, cell_row(0, 3, 0)};
      rows = {rows, csr_row(CSR_DIAGONAL_MODE, 64'd1)};
      rows = {rows, cell_row(1, 1, 4, 5, 6, 9, 10, 8)};
      rows = {rows, cell_row(0, 0, 3, 0, 1, 4, 5)};
      rows = {rows, cell_row(3, 0, 2, 3, 7, 6)};
      rows = {rows, csr_row(CSR_BLOCK_ALL, 64'd1)};
      rows = {rows, cell_row(1, 1, 0)};
      rows = {rows, csr_row(CSR_BLOCK_ALL, 64'd0)};
      rows = {rows, csr_row(CSR_BLOCK_THRESHOLD, '1)};
      rows = {rows, cell_row(1, 1, PREDICTED)};
      rows = {rows, csr_row(CSR_HASH_SEED, '1)};
      rows = {rows, csr_row(CSR_BLOCK_THRESHOLD, 64'h8000_0000_0000_0000)};
      rows = {rows, csr_row(CSR_GRID_WIDTH, 64'd1024)};
      rows = {rows, csr_row(CSR_GRID_HEIGHT, 64'd1024)};
      rows = {rows, cell_row(1023, 1023, PREDICTED)};
      rows = {rows, cell_row(1022, 1022, PREDICTED)};
      rows = {rows, cell_row(0, 0, PREDICTED)};
      rows = {rows, cell_row(1023, 0, PREDICTED)};
      rows = {rows, cell_row(0, 1023, PREDICTED)};
      rows = {rows, cell_row(512, 341, PREDICTED)};
      rows = {rows, csr_row(CSR_GRID_WIDTH, 64'd2047)};
      rows = {rows, csr_row(CSR_GRID_HEIGHT, 64'd2047)};
      rows = {rows, cell_row(1023, 1023, PREDICTED)};
      rows = {rows, cell_row(1022, 5, PREDICTED)};
      rows = {rows, cell_row(682, 1021, PREDICTED)};
      rows = {rows, csr_row(CSR_RSVD_A, {$urandom, $urandom})};
      rows = {rows, csr_row(CSR_RSVD_B, '1)};
      rows = {rows, cell_row(3, 4, PREDICTED)};
      rows = {rows, csr_row(CSR_GRID_WIDTH, 64'd0)};
      rows = {rows, cell_row(0, 0, 0)};
      rows = {rows, csr_row(CSR_GRID_WIDTH, 64'd5)};
      rows = {rows, csr_row(CSR_GRID_HEIGHT, 64'd0)};
      rows = {rows, cell_row(0, 0, 0)};

      foreach (rows[i]) begin
         if (rows[i].is_csr) write_csr(rows[i].idx, rows[i].data);
         else send_cell(rows[i]);
      end

      for (int phase = 0; phase < NUM_PHASES; phase++) begin
         write_csr(CSR_GRID_WIDTH, pick_dim());
         write_csr(CSR_GRID_HEIGHT, pick_dim());
         write_csr(CSR_HASH_SEED, {$urandom, $urandom});
         case ($urandom_range(7))
            0: v = '0;
            1: v = '1;
            2, 3: v = 64'h4000_0000_0000_0000;
            4, 5: v = 64'h8000_0000_0000_0000;
            default: v = {$urandom, $urandom};
         endcase
         write_csr(CSR_BLOCK_THRESHOLD, v);
         v = {$urandom, $urandom};
         v[0] = ($urandom_range(7) == 0);
         write_csr(CSR_BLOCK_ALL, v);
         v = {$urandom, $urandom};
         v[0] = 1'($urandom_range(1));
         write_csr(CSR_DIAGONAL_MODE, v);

         case (phase % 3)
            0: idle_pct = 0;
            1: idle_pct = 65;
            default: idle_pct = 28;
         endcase
         w_eff = (grid_w_cfg > MAX_DIM) ? MAX_DIM : int'(grid_w_cfg);
         h_eff = (grid_h_cfg > MAX_DIM) ? MAX_DIM : int'(grid_h_cfg);

         for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
            if (phase == 1 && i == ITEMS_PER_PHASE / 2) drain();
            if ($urandom_range(9) != 0) begin
               col = $urandom_range(w_eff - 1);
               row = $urandom_range(h_eff - 1);
            end else begin
               col = $urandom_range(1023);
               row = $urandom_range(1023);
            end
            send_cell(cell_row(col, row, PREDICTED));
         end
      end

      drain();
      if (mismatch_count == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule
